// ===== rtl/ctg_pkg.sv =====
// shared types, register codes and sine table arithmetic for the chirp tone generator
`default_nettype none

package ctg_pkg;

  // waveform codes
  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_SILENT = 2'd3
  } wave_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 3;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_WAVE_SELECT     = 3'd0;
  localparam cfg_index_t REG_START_INCREMENT = 3'd1;
  localparam cfg_index_t REG_INCREMENT_SLOPE = 3'd2;
  localparam cfg_index_t REG_START_AMPLITUDE = 3'd3;
  localparam cfg_index_t REG_AMPLITUDE_SLOPE = 3'd4;
  localparam cfg_index_t REG_TONE_LENGTH     = 3'd5;

  // field widths
  localparam int unsigned CFG_DATA_BITS = 48;
  localparam int unsigned INC_BITS      = 32;
  localparam int unsigned INC_ACC_BITS  = 48;
  localparam int unsigned AMP_BITS      = 16;
  localparam int unsigned AMP_ACC_BITS  = 40;
  localparam int unsigned LEN_BITS      = 32;
  localparam int unsigned WAVE_BITS     = 17;

  // reset values of the registers
  localparam wave_t                START_WAVE_RST = WAVE_SINE;
  localparam logic [INC_BITS-1:0]  START_INC_RST  = 32'd39370534;
  localparam logic [AMP_BITS-1:0]  START_AMP_RST  = 16'd26214;
  localparam logic [LEN_BITS-1:0]  TONE_LEN_RST   = 32'd48000;

  // full scale of amplitude and wave
  localparam logic [AMP_BITS-1:0] AMP_ONE = 16'd32768;

  // sine table arithmetic, pi/2 and one in Q30
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Q30         = 64'sd1073741824;
  localparam longint TAYLOR_DIV [1:6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};

  // one quarter-wave entry from a truncated taylor series, evaluated at elaboration
  function automatic logic [WAVE_BITS-1:0] sine_entry(input int unsigned k,
                                                      input int unsigned addr_bits);
    longint x;
    longint term;
    longint sum;
    longint r;
    x    = (longint'(k) * HALF_PI_Q30) >>> (addr_bits - 2);
    term = x;
    sum  = x;
    for (int i = 1; i <= 6; i++) begin
      term = term * x / Q30;
      term = term * x / Q30;
      term = -term / TAYLOR_DIV[i];
      sum  = sum + term;
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum * 64'sd32768 + (Q30 / 2)) / Q30;
    if (r > 64'sd32768) begin
      r = 64'sd32768;
    end
    return r[WAVE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ctg_wave.sv =====
// waveform lookup, amplitude scaling, rounding and saturation
`default_nettype none

module ctg_wave import ctg_pkg::*; #(
  parameter int unsigned PHASE_BITS     = 32,
  parameter int unsigned SINE_ADDR_BITS = 10,
  parameter int unsigned OUT_BITS       = 16
) (
  input  wire logic [PHASE_BITS-1:0]      phase,
  input  wire logic [AMP_BITS-1:0]        amp,
  input  wire wave_t                      wave_sel,
  output logic signed [OUT_BITS-1:0]      sample
);

  localparam int unsigned QUARTER    = 2 ** (SINE_ADDR_BITS - 2);
  localparam int unsigned SHIFT      = 31 - OUT_BITS;
  localparam int unsigned PROD_BITS  = AMP_BITS + 1 + WAVE_BITS;
  localparam logic [31:0] ROUND_HALF = 32'd1 << (SHIFT - 1);
  localparam logic [31:0] LIMIT      = (32'd1 << (OUT_BITS - 1)) - 32'd1;

  logic [WAVE_BITS-1:0]        sine_rom [QUARTER+1];
  logic [SINE_ADDR_BITS-1:0]   addr;
  logic [1:0]                  quad;
  logic [SINE_ADDR_BITS-3:0]   k;
  logic [SINE_ADDR_BITS-2:0]   rom_idx;
  logic [WAVE_BITS-1:0]        rom_val;
  logic signed [WAVE_BITS-1:0] wave;
  logic signed [PROD_BITS-1:0] prod;
  logic [31:0]                 mag;
  logic [31:0]                 rounded;
  logic [31:0]                 clipped;

  // quarter-wave table, constant at elaboration
  for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_rom
    assign sine_rom[gi] = sine_entry(gi, SINE_ADDR_BITS);
  end

  // quadrant folding of the sine table
  assign addr    = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign quad    = addr[SINE_ADDR_BITS-1 -: 2];
  assign k       = addr[SINE_ADDR_BITS-3:0];
  assign rom_idx = quad[0] ? ((SINE_ADDR_BITS-1)'(QUARTER) - {1'b0, k}) : {1'b0, k};
  assign rom_val = sine_rom[rom_idx];

  // wave select, full scale 32768
  always_comb begin
    case (wave_sel)
      WAVE_SINE:   wave = quad[1] ? -$signed(rom_val) : $signed(rom_val);
      WAVE_SQUARE: wave = phase[PHASE_BITS-1] ? -$signed({1'b0, AMP_ONE})
                                              : $signed({1'b0, AMP_ONE});
      // top bits of phase plus half a cycle, less half scale, is the phase read as signed
      WAVE_SAW:    wave = WAVE_BITS'($signed(phase[PHASE_BITS-1 -: 16]));
      default:     wave = '0;
    endcase
  end

  // scale, round half away from zero, saturate
  assign prod    = PROD_BITS'($signed({1'b0, amp})) * PROD_BITS'(wave);
  assign mag     = prod[PROD_BITS-1] ? 32'(-prod) : 32'(prod);
  assign rounded = (mag + ROUND_HALF) >> SHIFT;
  assign clipped = (rounded > LIMIT) ? LIMIT : rounded;
  assign sample  = prod[PROD_BITS-1] ? -$signed(clipped[OUT_BITS-1:0])
                                     : $signed(clipped[OUT_BITS-1:0]);

endmodule

`default_nettype wire

// ===== rtl/chirp_tone_generator.sv =====
// linear chirp tone source: ramped phase increment and amplitude, table sine, square, sawtooth
// a request is registered in the input stage, its sample then in the result register
// throughput: one sample per cycle; in_ready only drops when both stages hold a sample
// and out_ready is low, the phase/ramp update being one add per cycle in the input stage
// reset: synchronous active low; registers take their defaults, phase and index clear,
// ramp accumulators load the default start values; cfg_ready is always high
`default_nettype none

module chirp_tone_generator import ctg_pkg::*; #(
  parameter int unsigned PHASE_BITS     = 32,
  parameter int unsigned SINE_ADDR_BITS = 10,
  parameter int unsigned OUT_BITS       = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // sample request channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_restart,
  // sample result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [OUT_BITS-1:0]      out_sample,
  output logic                            out_last,
  // configuration write channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire cfg_index_t                 cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]   cfg_data
);

  // configuration registers
  wave_t                           wave_sel_r;
  logic [INC_BITS-1:0]             start_inc_r;
  logic signed [INC_ACC_BITS-1:0]  inc_slope_r;
  logic [AMP_BITS-1:0]             start_amp_r;
  logic signed [AMP_ACC_BITS-1:0]  amp_slope_r;
  logic [LEN_BITS-1:0]             tone_len_r;

  // generator state
  logic [PHASE_BITS-1:0]           phase_r, phase_nxt;
  logic [INC_ACC_BITS-1:0]         inc_acc_r, inc_acc_nxt;
  logic [AMP_ACC_BITS-1:0]         amp_acc_r, amp_acc_nxt;
  logic [LEN_BITS-1:0]             index_r, index_nxt;

  // input stage and result register
  logic                            s1_valid_r;
  logic [PHASE_BITS-1:0]           s1_phase_r;
  logic [AMP_BITS-1:0]             s1_amp_r;
  logic                            s1_last_r;
  logic                            out_valid_r;
  logic signed [OUT_BITS-1:0]      out_sample_r;
  logic                            out_last_r;

  logic                            in_xfer;
  logic                            adv;
  logic [PHASE_BITS-1:0]           phase_base;
  logic [INC_ACC_BITS-1:0]         inc_base;
  logic [AMP_ACC_BITS-1:0]         amp_base;
  logic [LEN_BITS-1:0]             index_base;
  logic [INC_ACC_BITS-1:0]         inc_load;
  logic [AMP_ACC_BITS-1:0]         amp_load;
  logic [INC_BITS-1:0]             inc;
  logic [PHASE_BITS-1:0]           inc_scaled;
  logic [AMP_BITS-1:0]             amp_raw;
  logic [AMP_BITS-1:0]             amp_clamped;
  logic                            last;
  logic signed [OUT_BITS-1:0]      sample;

  // handshakes
  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv || !s1_valid_r;
  assign in_xfer   = in_valid && in_ready;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_sel_r  <= START_WAVE_RST;
      start_inc_r <= START_INC_RST;
      inc_slope_r <= '0;
      start_amp_r <= START_AMP_RST;
      amp_slope_r <= '0;
      tone_len_r  <= TONE_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WAVE_SELECT:     wave_sel_r  <= wave_t'(cfg_data[1:0]);
        REG_START_INCREMENT: start_inc_r <= cfg_data[INC_BITS-1:0];
        REG_INCREMENT_SLOPE: inc_slope_r <= $signed(cfg_data[INC_ACC_BITS-1:0]);
        REG_START_AMPLITUDE: start_amp_r <= cfg_data[AMP_BITS-1:0];
        REG_AMPLITUDE_SLOPE: amp_slope_r <= $signed(cfg_data[AMP_ACC_BITS-1:0]);
        REG_TONE_LENGTH:     tone_len_r  <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ramp start values
  assign inc_load = {start_inc_r, 16'd0};
  assign amp_load = {start_amp_r, 24'd0};

  // restart clears the state before this sample
  assign phase_base = in_restart ? '0 : phase_r;
  assign inc_base   = in_restart ? inc_load : inc_acc_r;
  assign amp_base   = in_restart ? amp_load : amp_acc_r;
  assign index_base = in_restart ? '0 : index_r;

  // increment scaled to the phase width
  assign inc = inc_base[INC_ACC_BITS-1 -: INC_BITS];
  if (PHASE_BITS >= INC_BITS) begin : g_inc_up
    assign inc_scaled = PHASE_BITS'(inc) << (PHASE_BITS - INC_BITS);
  end else begin : g_inc_down
    assign inc_scaled = inc[INC_BITS-1 -: PHASE_BITS];
  end

  // amplitude above one is held at one
  assign amp_raw     = amp_base[AMP_ACC_BITS-1 -: AMP_BITS];
  assign amp_clamped = (amp_raw > AMP_ONE) ? AMP_ONE : amp_raw;

  // end of tone, length zero wraps to the full index range
  assign last = (index_base == (tone_len_r - LEN_BITS'(1)));

  // state advance
  always_comb begin
    phase_nxt = phase_base + inc_scaled;
    if (last) begin
      index_nxt   = '0;
      inc_acc_nxt = inc_load;
      amp_acc_nxt = amp_load;
    end else begin
      index_nxt   = index_base + LEN_BITS'(1);
      inc_acc_nxt = inc_base + inc_slope_r;
      amp_acc_nxt = amp_base + amp_slope_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      inc_acc_r <= {START_INC_RST, 16'd0};
      amp_acc_r <= {START_AMP_RST, 24'd0};
      index_r   <= '0;
    end else if (in_xfer) begin
      phase_r   <= phase_nxt;
      inc_acc_r <= inc_acc_nxt;
      amp_acc_r <= amp_acc_nxt;
      index_r   <= index_nxt;
    end
  end

  // input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_phase_r <= phase_nxt;
      s1_amp_r   <= amp_clamped;
      s1_last_r  <= last;
    end
  end

  ctg_wave #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .OUT_BITS       (OUT_BITS)
  ) u_wave (
    .phase    (s1_phase_r),
    .amp      (s1_amp_r),
    .wave_sel (wave_sel_r),
    .sample   (sample)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_sample_r <= sample;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/ctg_checker.sv =====
// port-level checks for the chirp tone generator, bound to the top level
`default_nettype none

module ctg_checker #(
  parameter int unsigned OUT_BITS = 16
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [OUT_BITS-1:0]   out_sample,
  input wire logic                  out_last,
  input wire logic                  cfg_ready
);

  localparam logic [OUT_BITS-1:0] MOST_NEGATIVE = {1'b1, {(OUT_BITS-1){1'b0}}};

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("result changed while stalled");

  // saturation is symmetric, the most negative code never appears
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample != MOST_NEGATIVE)
    else $error("sample outside symmetric range");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a consumer taking results never stalls the request side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready && cfg_ready)
    else $error("request side stalled while results drain");

endmodule

bind chirp_tone_generator ctg_checker #(
  .OUT_BITS (OUT_BITS)
) u_ctg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample),
  .out_last   (out_last),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking testbench for the chirp tone generator with its own sample predictor
module tb_top;
  import ctg_pkg::*;

  localparam int unsigned PHASE_W          = 32;
  localparam int unsigned ADDR_W           = 10;
  localparam int unsigned SAMPLE_W         = 16;
  localparam int unsigned QUARTER_LEN      = 1 << (ADDR_W - 2);
  localparam int unsigned RESET_CYCLES     = 12;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned RANDOM_TONES     = 21;
  localparam int unsigned SAMPLES_PER_TONE = 40;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam int unsigned IDLE_PERCENT     = 34;
  localparam int unsigned RESTART_PERCENT  = 6;
  localparam cfg_index_t  REG_SPARE_LO     = 3'd6;
  localparam cfg_index_t  REG_SPARE_HI     = 3'd7;
  localparam longint      Q30_ONE          = 64'sd1073741824;
  localparam longint      HALF_PI_Q30_VAL  = 64'sd1686629713;
  localparam longint      FULL_SCALE       = 64'sd32768;
  localparam longint      SAMPLE_MAX       = 64'sd32767;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } tone_sample_t;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_valid   = 1'b0;
  logic                        in_ready;
  logic                        in_restart = 1'b0;
  logic                        out_valid;
  logic                        out_ready  = 1'b0;
  logic signed [SAMPLE_W-1:0]  out_sample;
  logic                        out_last;
  logic                        cfg_valid  = 1'b0;
  logic                        cfg_ready;
  cfg_index_t                  cfg_index  = REG_WAVE_SELECT;
  logic [CFG_DATA_BITS-1:0]    cfg_data   = '0;

  // predictor copy of the registers and the tone state
  logic [1:0]                  wave_sel;
  logic [INC_BITS-1:0]         start_inc;
  logic [INC_ACC_BITS-1:0]     inc_slope;
  logic [AMP_BITS-1:0]         start_amp;
  logic [AMP_ACC_BITS-1:0]     amp_slope;
  logic [LEN_BITS-1:0]         tone_len;
  logic [PHASE_W-1:0]          phase;
  logic [INC_ACC_BITS-1:0]     inc_acc;
  logic [AMP_ACC_BITS-1:0]     amp_acc;
  logic [LEN_BITS-1:0]         sample_idx;
  int                          quarter_sine [0:QUARTER_LEN];

  tone_sample_t                expected_samples [$];
  bit                          gaps_on = 1'b1;
  int unsigned                 cycle_count;
  int unsigned                 mismatch_count;
  int unsigned                 samples_checked;
  int unsigned                 tones_seen;
  int unsigned                 cfg_writes;

  chirp_tone_generator #(
    .PHASE_BITS     (PHASE_W),
    .SINE_ADDR_BITS (ADDR_W),
    .OUT_BITS       (SAMPLE_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one quarter-wave point from the truncated taylor series
  function automatic int sine_point(input int k);
    longint x;
    longint term;
    longint sum;
    longint r;
    x    = (longint'(k) * HALF_PI_Q30_VAL) / longint'(QUARTER_LEN);
    term = x;
    sum  = x;
    for (int i = 1; i <= 6; i++) begin
      term = term * x / Q30_ONE;
      term = term * x / Q30_ONE;
      term = -term / longint'((2 * i) * (2 * i + 1));
      sum  = sum + term;
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum * FULL_SCALE + Q30_ONE / 2) / Q30_ONE;
    if (r > FULL_SCALE) begin
      r = FULL_SCALE;
    end
    return int'(r);
  endfunction

  // ramp accumulators take the start values
  function automatic void reload_ramps();
    inc_acc = {start_inc, 16'h0000};
    amp_acc = {start_amp, 24'h000000};
  endfunction

  // one sample of the tone: advance the phase, shape, scale, then step the ramps
  function automatic tone_sample_t chirp_advance(input logic restart);
    tone_sample_t           res;
    logic [ADDR_W-1:0]      addr;
    logic [PHASE_W-1:0]     shifted;
    longint                 amp;
    longint                 wave;
    longint                 prod;
    longint                 mag;
    int                     k;
    if (restart) begin
      phase      = '0;
      sample_idx = '0;
      reload_ramps();
    end
    phase = phase + inc_acc[INC_ACC_BITS-1 -: INC_BITS];
    amp   = longint'(amp_acc[AMP_ACC_BITS-1 -: AMP_BITS]);
    if (amp > FULL_SCALE) begin
      amp = FULL_SCALE;
    end
    case (wave_t'(wave_sel))
      WAVE_SINE: begin
        addr = phase[PHASE_W-1 -: ADDR_W];
        k    = int'(addr[ADDR_W-3:0]);
        wave = longint'(addr[ADDR_W-2] ? quarter_sine[QUARTER_LEN - k] : quarter_sine[k]);
        if (addr[ADDR_W-1]) begin
          wave = -wave;
        end
      end
      WAVE_SQUARE: wave = phase[PHASE_W-1] ? -FULL_SCALE : FULL_SCALE;
      WAVE_SAW: begin
        shifted = phase + {1'b1, {(PHASE_W-1){1'b0}}};
        wave    = longint'(shifted[PHASE_W-1 -: 16]);
        wave    = wave - FULL_SCALE;
      end
      default: wave = 64'sd0;
    endcase
    // round half away from zero, then saturate
    prod = amp * wave;
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + 64'sd16384) >>> 15;
    if (mag > SAMPLE_MAX) begin
      mag = SAMPLE_MAX;
    end
    res.sample = (prod < 0) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    res.last   = (sample_idx == tone_len - 32'd1);
    if (res.last) begin
      sample_idx = '0;
      reload_ramps();
    end else begin
      sample_idx = sample_idx + 32'd1;
      inc_acc    = inc_acc + inc_slope;
      amp_acc    = amp_acc + amp_slope;
    end
    return res;
  endfunction

  // register writes seen on the configuration port
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      cfg_writes++;
      case (cfg_index)
        REG_WAVE_SELECT:     wave_sel  = cfg_data[1:0];
        REG_START_INCREMENT: start_inc = cfg_data[INC_BITS-1:0];
        REG_INCREMENT_SLOPE: inc_slope = cfg_data[INC_ACC_BITS-1:0];
        REG_START_AMPLITUDE: start_amp = cfg_data[AMP_BITS-1:0];
        REG_AMPLITUDE_SLOPE: amp_slope = cfg_data[AMP_ACC_BITS-1:0];
        REG_TONE_LENGTH:     tone_len  = cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // each accepted request gives one expected sample
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_samples.push_back(chirp_advance(in_restart));
    end
  end

  task automatic report_mismatch(input string field, input logic signed [SAMPLE_W-1:0] want,
                                 input logic signed [SAMPLE_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch on %s of sample %0d: expected %0d, got %0d",
               field, samples_checked, want, got);
    end
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    tone_sample_t want;
    if (rst_n && out_valid && out_ready) begin
      samples_checked++;
      if (out_last === 1'b1) begin
        tones_seen++;
      end
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected transfer", '0, out_sample);
      end else begin
        want = expected_samples.pop_front();
        if (out_sample !== want.sample) begin
          report_mismatch("sample", want.sample, out_sample);
        end
        if (out_last !== want.last) begin
          report_mismatch("last", SAMPLE_W'(want.last), SAMPLE_W'(out_last));
        end
      end
    end
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_ready <= !(gaps_on && ($urandom_range(99) < IDLE_PERCENT));
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding",
               cycle_count, expected_samples.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // one request transfer, valid held from the previous transfer unless a gap is taken
  task automatic send_sample(input logic restart);
    if (gaps_on && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  task automatic write_setting(input logic [CFG_DATA_BITS-1:0] wave,
                               input logic [CFG_DATA_BITS-1:0] inc,
                               input logic [CFG_DATA_BITS-1:0] islope,
                               input logic [CFG_DATA_BITS-1:0] amp,
                               input logic [CFG_DATA_BITS-1:0] aslope,
                               input logic [CFG_DATA_BITS-1:0] len);
    write_reg(REG_WAVE_SELECT, wave);
    write_reg(REG_START_INCREMENT, inc);
    write_reg(REG_INCREMENT_SLOPE, islope);
    write_reg(REG_START_AMPLITUDE, amp);
    write_reg(REG_AMPLITUDE_SLOPE, aslope);
    write_reg(REG_TONE_LENGTH, len);
    cfg_release();
  endtask

  // stop requests and let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    // the last request is queued at its own edge, so look only after the next one
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // default registers straight out of reset
  task automatic test_reset_state();
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b1);
    drain();
  endtask

  // full-scale square at the top increment must clip; every phase it reaches is in the negative half
  task automatic test_square_saturation();
    write_setting(48'(WAVE_SQUARE), 48'hFFFF_FFFF, '0, 48'(AMP_ONE), '0, 48'd2);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b0);
    drain();
  endtask

  // amplitude register above one, one-sample tones
  task automatic test_saw_above_one();
    write_setting(48'(WAVE_SAW), 48'h7FFF_FFFF, '0, 48'hFFFF, '0, 48'd1);
    send_sample(1'b1);
    send_sample(1'b0);
    drain();
  endtask

  task automatic test_silent_code();
    write_setting(48'(WAVE_SILENT), '0, '0, 48'(AMP_ONE), '0, 48'd5);
    send_sample(1'b1);
    send_sample(1'b0);
    drain();
  endtask

  // slope extremes, ramps wrapping; zero length means a very long tone
  task automatic test_ramp_extremes();
    write_setting(48'(WAVE_SINE), 48'h1234_5678, 48'h7FFF_FFFF_FFFF, 48'(AMP_ONE),
                  48'h80_0000_0000, '0);
    send_sample(1'b1);
    repeat (3) send_sample(1'b0);
    drain();
    write_setting(48'(WAVE_SINE), 48'h0800_0000, 48'h8000_0000_0000, 48'd100,
                  48'h7F_FFFF_FFFF, 48'd3);
    send_sample(1'b1);
    repeat (4) send_sample(1'b0);
    drain();
  endtask

  // writes to unused indexes leave the registers alone
  task automatic test_spare_index();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    cfg_release();
    send_sample(1'b0);
    drain();
  endtask

  // random settings, each followed by a run of samples with occasional restarts
  task automatic test_random_tones();
    logic [CFG_DATA_BITS-1:0] pad;
    logic [CFG_DATA_BITS-1:0] inc;
    logic [CFG_DATA_BITS-1:0] islope;
    logic [CFG_DATA_BITS-1:0] amp;
    logic [CFG_DATA_BITS-1:0] aslope;
    logic [CFG_DATA_BITS-1:0] len;
    for (int t = 0; t < RANDOM_TONES; t++) begin
      // one setting in the middle runs with no idling at all
      gaps_on = (t != RANDOM_TONES / 2);
      pad = 48'({$urandom, $urandom});
      case ($urandom_range(3))
        0:       inc = '0;
        1:       inc = 48'hFFFF_FFFF;
        2:       inc = 48'($urandom_range(0, 32'h0400_0000));
        default: inc = 48'($urandom);
      endcase
      case ($urandom_range(4))
        0:       islope = '0;
        1:       islope = 48'h7FFF_FFFF_FFFF;
        2:       islope = 48'h8000_0000_0000;
        3:       islope = 48'({$urandom, $urandom});
        default: begin
          islope = 48'($urandom_range(0, 32'h00FF_FFFF));
          if ($urandom_range(1)) islope = -islope;
        end
      endcase
      case ($urandom_range(4))
        0:       amp = '0;
        1:       amp = 48'(AMP_ONE);
        2:       amp = 48'hFFFF;
        3:       amp = 48'($urandom_range(0, 32768));
        default: amp = 48'($urandom_range(0, 16'hFFFF));
      endcase
      case ($urandom_range(4))
        0:       aslope = '0;
        1:       aslope = 48'h7F_FFFF_FFFF;
        2:       aslope = 48'h80_0000_0000;
        3:       aslope = 48'({$urandom, $urandom}) & 48'hFF_FFFF_FFFF;
        default: begin
          aslope = 48'($urandom_range(0, 32'h0FFF_FFFF));
          if ($urandom_range(1)) aslope = (-aslope) & 48'hFF_FFFF_FFFF;
        end
      endcase
      case ($urandom_range(9))
        0:       len = '0;
        1:       len = 48'hFFFF_FFFF;
        2:       len = 48'($urandom);
        default: len = 48'($urandom_range(1, 40));
      endcase
      // unused upper data bits carry noise
      write_setting({pad[47:2], 2'($urandom_range(3))}, {pad[47:32], inc[31:0]}, islope,
                    {pad[47:16], amp[15:0]}, {pad[47:40], aslope[39:0]},
                    {pad[47:32], len[31:0]});
      for (int n = 0; n < SAMPLES_PER_TONE; n++) begin
        if (n == 0) begin
          send_sample(1'($urandom_range(1)));
        end else begin
          send_sample($urandom_range(99) < RESTART_PERCENT);
        end
      end
      drain();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      quarter_sine[k] = sine_point(k);
    end
    // predictor state after reset
    wave_sel   = START_WAVE_RST;
    start_inc  = START_INC_RST;
    inc_slope  = '0;
    start_amp  = START_AMP_RST;
    amp_slope  = '0;
    tone_len   = TONE_LEN_RST;
    phase      = '0;
    sample_idx = '0;
    reload_ramps();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_square_saturation();
    test_saw_above_one();
    test_silent_code();
    test_ramp_extremes();
    test_spare_index();
    test_random_tones();
    $display("checked %0d samples across %0d register writes, %0d tone ends",
             samples_checked, cfg_writes, tones_seen);
    $display("all four waveforms, ramp and amplitude extremes, restarts and random stalls");
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== chirp_tone_generator.f =====
rtl/ctg_pkg.sv
rtl/ctg_wave.sv
rtl/chirp_tone_generator.sv
rtl/ctg_checker.sv
bench/tb_top.sv
